FILE: design/dense_graph_shortest_paths_macros.svh
`ifndef DENSE_GRAPH_SHORTEST_PATHS_MACROS_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_MACROS_SVH

// same-cycle implication
`define DGSP_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define DGSP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: design/dgsp_pkg.sv
package dgsp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int COUNT_W     = NODE_W + 1;
  localparam int WEIGHT_W    = 14;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = COUNT_W;

  localparam logic [WEIGHT_W-1:0] UNREACHED = WEIGHT_W'(9999);

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

endpackage

FILE: design/dense_graph_shortest_paths.sv
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------------
// input     | start, busy        | edge_weight, last_entry
// result    | strobe (no stall)  | vertex_index, distance, reachable, last_result
// config    | wr_en              | wr_index, wr_data
//
// a matrix beat is taken while start is high and busy is low; the beat with
// last_entry raises busy until the last result has been strobed
// search length is set by the single
// read port of the distance memory, scanned once per selection and once per relax
// results come on consecutive cycles, one per node; the receiver cannot stall
// rst is synchronous and clears control state; memories are not cleared
`include "dense_graph_shortest_paths_macros.svh"

module dense_graph_shortest_paths
  import dgsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [WEIGHT_W-1:0]    edge_weight,
  input  logic                   last_entry,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output logic                   strobe,
  output logic [NODE_W-1:0]      vertex_index,
  output logic [WEIGHT_W-1:0]    distance,
  output logic                   reachable,
  output logic                   last_result
);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_LOAD = 3'd0;
  localparam logic [STATE_W-1:0] S_INIT = 3'd1;
  localparam logic [STATE_W-1:0] S_SEL  = 3'd2;
  localparam logic [STATE_W-1:0] S_MUL  = 3'd3;
  localparam logic [STATE_W-1:0] S_REL  = 3'd4;
  localparam logic [STATE_W-1:0] S_OUT  = 3'd5;

  logic [WEIGHT_W-1:0] weight_mem [STORE_DEPTH];
  logic [WEIGHT_W-1:0] dist_mem [MAX_NODES];

  logic [STATE_W-1:0]   state;
  logic [ADDR_W-1:0]    load_pointer;
  logic [COUNT_W-1:0]   node_count;
  logic [NODE_W-1:0]    source_vertex;
  logic [COUNT_W-1:0]   n_act;
  logic [COUNT_W-1:0]   cnt;
  logic [COUNT_W-1:0]   round_cnt;
  logic                 pv;
  logic [NODE_W-1:0]    pk;
  logic [WEIGHT_W-1:0]  best;
  logic [NODE_W-1:0]    at;
  logic [WEIGHT_W-1:0]  dv;
  logic [ADDR_W-1:0]    base;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] touched;
  logic [WEIGHT_W-1:0]  dist_q;
  logic [WEIGHT_W-1:0]  w_q;

  logic                 issue;
  logic [ADDR_W-1:0]    w_ra;
  logic [WEIGHT_W-1:0]  d_eff;
  logic [WEIGHT_W:0]    sum;
  logic                 relax_hit;
  logic                 scan_done;
  logic                 round_last;
  logic                 dist_we;
  logic [NODE_W-1:0]    dist_wa;
  logic [WEIGHT_W-1:0]  dist_wd;
  logic [COUNT_W-1:0]   n_clamp;
  logic [NODE_W-1:0]    src_sel;
  logic                 load_we;

  assign busy    = (state != S_LOAD);
  assign load_we = start && !busy;

  always_comb begin
    if (node_count > COUNT_W'(MAX_NODES)) begin
      n_clamp = COUNT_W'(MAX_NODES);
    end else if (node_count < COUNT_W'(2)) begin
      n_clamp = COUNT_W'(2);
    end else begin
      n_clamp = node_count;
    end
  end

  assign src_sel    = ({1'b0, source_vertex} < n_act) ? source_vertex : '0;
  assign issue      = ((state == S_SEL) || (state == S_REL) || (state == S_OUT))
                      && (cnt < n_act);
  assign w_ra       = base + {{(ADDR_W - NODE_W){1'b0}}, cnt[NODE_W-1:0]};
  assign d_eff      = touched[pk] ? dist_q : UNREACHED;
  assign sum        = {1'b0, dv} + {1'b0, w_q};
  assign relax_hit  = pv && (state == S_REL) && (w_q != '0)
                      && (sum < {1'b0, d_eff}) && (sum < {1'b0, UNREACHED});
  assign scan_done  = (cnt == n_act) && !pv;
  assign round_last = ((round_cnt + COUNT_W'(2)) == n_act);
  assign dist_we    = (state == S_INIT) || relax_hit;
  assign dist_wa    = (state == S_INIT) ? src_sel : pk;
  assign dist_wd    = (state == S_INIT) ? '0 : sum[WEIGHT_W-1:0];

  // memories
  always_ff @(posedge clk) begin
    if (load_we) begin
      weight_mem[load_pointer] <= edge_weight;
    end
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_q <= dist_mem[cnt[NODE_W-1:0]];
    w_q    <= weight_mem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      load_pointer  <= '0;
      node_count    <= COUNT_W'(MAX_NODES);
      source_vertex <= '0;
      cnt           <= '0;
      pv            <= 1'b0;
      strobe        <= 1'b0;
      visited       <= '0;
      touched       <= '0;
    end else begin
      strobe <= 1'b0;
      if (wr_en) begin
        if (wr_index == REG_NODE_COUNT) begin
          node_count <= wr_data[COUNT_W-1:0];
        end else if (wr_index == REG_SOURCE_VERTEX) begin
          source_vertex <= wr_data[NODE_W-1:0];
        end
      end
      pv <= issue;
      if (issue) begin
        cnt <= cnt + COUNT_W'(1);
        pk  <= cnt[NODE_W-1:0];
      end
      unique case (state)
        S_LOAD: begin
          if (load_we) begin
            load_pointer <= load_pointer + ADDR_W'(1);
            if (last_entry) begin
              n_act <= n_clamp;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          visited   <= '0;
          touched   <= MAX_NODES'(1) << src_sel;
          round_cnt <= '0;
          cnt       <= '0;
          best      <= UNREACHED;
          state     <= S_SEL;
        end
        S_SEL: begin
          if (pv && !visited[pk] && (d_eff <= best)) begin
            best <= d_eff;
            at   <= pk;
          end
          if (scan_done) begin
            visited[at] <= 1'b1;
            dv          <= best;
            cnt         <= '0;
            if (best == UNREACHED) begin
              round_cnt <= round_cnt + COUNT_W'(1);
              best      <= UNREACHED;
              state     <= round_last ? S_OUT : S_SEL;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          base  <= {{(ADDR_W - NODE_W){1'b0}}, at}
                   * {{(ADDR_W - COUNT_W){1'b0}}, n_act};
          cnt   <= '0;
          state <= S_REL;
        end
        S_REL: begin
          if (relax_hit) begin
            touched[pk] <= 1'b1;
          end
          if (scan_done) begin
            round_cnt <= round_cnt + COUNT_W'(1);
            best      <= UNREACHED;
            cnt       <= '0;
            state     <= round_last ? S_OUT : S_SEL;
          end
        end
        S_OUT: begin
          if (pv) begin
            strobe       <= 1'b1;
            vertex_index <= pk;
            distance     <= d_eff;
            reachable    <= (d_eff != UNREACHED);
            last_result  <= ({1'b0, pk} == (n_act - COUNT_W'(1)));
          end
          if (scan_done) begin
            load_pointer <= '0;
            state        <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `DGSP_ASSERT_NOW(a_strobe_busy, clk, rst, strobe, busy, "result beat while idle")
  `DGSP_ASSERT_NEXT(a_last_ends, clk, rst, strobe && last_result, !strobe,
                    "result beat after the last one")
  `DGSP_ASSERT_NEXT(a_burst_gapless, clk, rst, strobe && !last_result, strobe,
                    "gap inside a result burst")
  `DGSP_ASSERT_NEXT(a_last_starts, clk, rst, start && !busy && last_entry, busy,
                    "search did not start after the last entry")

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dgsp_pkg::*;

  localparam int CLK_PERIOD         = 10;
  localparam int TIMEOUT_CYCLES     = 500000;
  localparam int SETTLE_CYCLES      = 4;
  localparam int TAIL_CYCLES        = 20;
  localparam int RANDOM_BEATS       = 310;

  typedef logic [WEIGHT_W-1:0] weight_t;

  typedef enum int {MIX_SPARSE, MIX_HEAVY} weight_mix_t;

  typedef struct {
    logic [NODE_W-1:0]   node;
    logic [WEIGHT_W-1:0] path_len;
    logic                reach;
    logic                tail;
  } path_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [WEIGHT_W-1:0]    edge_weight = '0;
  logic                   last_entry = 1'b0;
  logic                   wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data = '0;
  logic                   strobe;
  logic [NODE_W-1:0]      vertex_index;
  logic [WEIGHT_W-1:0]    distance;
  logic                   reachable;
  logic                   last_result;

  dense_graph_shortest_paths dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .edge_weight  (edge_weight),
    .last_entry   (last_entry),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .strobe       (strobe),
    .vertex_index (vertex_index),
    .distance     (distance),
    .reachable    (reachable),
    .last_result  (last_result)
  );

  // predictor state
  weight_t                weight_mem [STORE_DEPTH];
  logic [ADDR_W-1:0]      load_ptr = '0;
  logic [COUNT_W-1:0]     cfg_node_count = COUNT_W'(MAX_NODES);
  logic [NODE_W-1:0]      cfg_source = '0;
  path_result_t           expected_paths [$];
  path_result_t           oldest_path;

  int  error_count  = 0;
  int  beats_sent   = 0;
  int  searches_run = 0;
  int  results_seen = 0;
  int  burst_left   = 0;
  bit  gaps_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL dense_graph_shortest_paths");
    $finish;
  end

  function automatic int active_count();
    int n;
    n = cfg_node_count;
    if (n > MAX_NODES) n = MAX_NODES;
    if (n < 2) n = 2;
    return n;
  endfunction

  function automatic void predict_paths();
    int           n;
    int           src;
    int           v;
    int unsigned  best;
    int unsigned  dv;
    int unsigned  w;
    int unsigned  s;
    weight_t      node_dist [MAX_NODES];
    bit           seen [MAX_NODES];
    path_result_t r;
    n = active_count();
    src = (cfg_source < n) ? cfg_source : 0;
    for (int j = 0; j < MAX_NODES; j++) begin
      node_dist[j] = UNREACHED;
      seen[j] = 1'b0;
    end
    node_dist[src] = '0;
    for (int round = 0; round < n - 1; round++) begin
      best = UNREACHED;
      v = 0;
      // ties go to the highest index
      for (int k = 0; k < n; k++) begin
        if (!seen[k] && node_dist[k] <= best) begin
          best = node_dist[k];
          v = k;
        end
      end
      seen[v] = 1'b1;
      dv = node_dist[v];
      if (dv != UNREACHED) begin
        for (int j = 0; j < n; j++) begin
          w = weight_mem[(v * n + j) % STORE_DEPTH];
          s = dv + w;
          if (w != 0 && s < node_dist[j] && s < UNREACHED) node_dist[j] = weight_t'(s);
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      r.node     = NODE_W'(k);
      r.path_len = node_dist[k];
      r.reach    = (node_dist[k] != UNREACHED);
      r.tail     = (k == n - 1);
      expected_paths.push_back(r);
    end
    searches_run++;
  endfunction

  function automatic void store_entry(input weight_t w, input logic tail);
    weight_mem[load_ptr] = w;
    load_ptr = load_ptr + 1'b1;
    if (tail) begin
      predict_paths();
      load_ptr = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [WEIGHT_W-1:0] want,
                                      input logic [WEIGHT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) begin
      if (expected_paths.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual node %0d distance %0d",
                 $time, vertex_index, distance);
        error_count++;
      end else begin
        oldest_path = expected_paths.pop_front();
        check_field("vertex_index", WEIGHT_W'(oldest_path.node), WEIGHT_W'(vertex_index));
        check_field("distance", oldest_path.path_len, distance);
        check_field("reachable", WEIGHT_W'(oldest_path.reach), WEIGHT_W'(reachable));
        check_field("last_result", WEIGHT_W'(oldest_path.tail), WEIGHT_W'(last_result));
        results_seen++;
      end
    end
  end

  task automatic send_entry(input weight_t w, input logic tail);
    start       <= 1'b1;
    edge_weight <= w;
    last_entry  <= tail;
    @(posedge clk);
    while (busy) @(posedge clk);
    store_entry(w, tail);
    beats_sent++;
    // bursts of beats with random gaps
    if (gaps_on && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic send_matrix(input weight_t entries [$]);
    foreach (entries[i]) send_entry(entries[i], i == entries.size() - 1);
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    while (expected_paths.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_results_done();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    if (idx == REG_NODE_COUNT) cfg_node_count = val;
    else if (idx == REG_SOURCE_VERTEX) cfg_source = val[NODE_W-1:0];
    wr_en <= 1'b0;
  endtask

  function automatic weight_t rand_weight(input weight_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    if (mix == MIX_SPARSE) return (roll < 60) ? weight_t'(0) : weight_t'($urandom_range(1, 40));
    if (roll < 20) return weight_t'(0);
    if (roll < 50) return weight_t'($urandom_range(1, 9998));
    if (roll < 80) return weight_t'($urandom_range(4000, 6000));
    return weight_t'($urandom_range(9999, 16383));
  endfunction

  // reset register values, full 64 node matrix, pointer wraps past the store
  task automatic test_full_matrix_wraparound();
    weight_t entries [$];
    repeat (STORE_DEPTH + 4) entries.push_back(rand_weight(MIX_SPARSE));
    send_matrix(entries);
  endtask

  // node count below range, heavy weights never relax
  task automatic test_two_node_heavy_edges();
    weight_t entries [$];
    write_reg(REG_NODE_COUNT, CFG_DATA_W'(0));
    write_reg(REG_SOURCE_VERTEX, CFG_DATA_W'(1));
    entries = {weight_t'(0), weight_t'(9998), weight_t'(16383), weight_t'(0)};
    send_matrix(entries);
  endtask

  task automatic test_tie_break();
    weight_t entries [$];
    write_reg(REG_NODE_COUNT, CFG_DATA_W'(3));
    write_reg(REG_SOURCE_VERTEX, CFG_DATA_W'(0));
    entries = {weight_t'(0), weight_t'(5), weight_t'(5),
               weight_t'(0), weight_t'(0), weight_t'(1),
               weight_t'(0), weight_t'(1), weight_t'(0)};
    send_matrix(entries);
  endtask

  // sum reaching exactly 9999 stays unreachable, source beyond node count
  task automatic test_sum_threshold_bad_source();
    weight_t entries [$];
    write_reg(REG_SOURCE_VERTEX, CFG_DATA_W'(63));
    entries = {weight_t'(0), weight_t'(5000), weight_t'(0),
               weight_t'(0), weight_t'(0), weight_t'(4999),
               weight_t'(0), weight_t'(0), weight_t'(0)};
    send_matrix(entries);
  endtask

  // node count above range, short load keeps older slots
  task automatic test_count_saturation_short_load();
    weight_t entries [$];
    write_reg(REG_NODE_COUNT, CFG_DATA_W'(127));
    write_reg(REG_SOURCE_VERTEX, CFG_DATA_W'(5));
    entries = {weight_t'(7), weight_t'(0), weight_t'(12)};
    send_matrix(entries);
  endtask

  task automatic test_random_graphs();
    int          sent;
    int          n;
    int          len;
    int          shape;
    weight_mix_t mix;
    weight_t     entries [$];
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      // small node counts from the first graph on
      if (sent == 0 || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: begin
            write_reg(REG_NODE_COUNT, CFG_DATA_W'($urandom_range(0, 1)));
          end
          1: begin
            write_reg(REG_NODE_COUNT, CFG_DATA_W'($urandom_range(9, 10)));
          end
          default: begin
            write_reg(REG_NODE_COUNT, CFG_DATA_W'($urandom_range(2, 6)));
          end
        endcase
        if ($urandom_range(0, 9) == 0) begin
          write_reg(REG_SOURCE_VERTEX, CFG_DATA_W'($urandom_range(0, 127)));
        end else if ($urandom_range(0, 2) != 0) begin
          write_reg(REG_SOURCE_VERTEX, CFG_DATA_W'($urandom_range(0, active_count() - 1)));
        end
      end else if ($urandom_range(0, 3) == 0) begin
        wait_results_done();
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      mix = ($urandom_range(0, 1) == 0) ? MIX_SPARSE : MIX_HEAVY;
      n = active_count();
      shape = $urandom_range(0, 9);
      // mostly whole matrices, some short and some overlong loads
      if (shape < 7) len = n * n;
      else if (shape == 7) len = $urandom_range(1, n * n - 1);
      else len = n * n + $urandom_range(1, 6);
      entries.delete();
      repeat (len) entries.push_back(rand_weight(mix));
      send_matrix(entries);
      sent += len;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_full_matrix_wraparound();
    test_two_node_heavy_edges();
    test_tie_break();
    test_sum_threshold_bad_source();
    test_count_saturation_short_load();
    test_random_graphs();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d matrix beats and %0d searches, %0d node distances checked",
             beats_sent, searches_run, results_seen);
    $display("node counts 2 to 64 incl. out of range values, heavy and sparse weights");
    if (error_count == 0) begin
      $display("PASS dense_graph_shortest_paths");
    end else begin
      $display("FAIL dense_graph_shortest_paths");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/dgsp_pkg.sv
design/dense_graph_shortest_paths.sv
dv/tb_top.sv
